>>> sv/assert_macros.svh
// Assertion macros used by the tiler RTL; expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define VCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/vct_pkg.sv
// Constants and types shared by the volume chunk tiler files.
package vct_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 31;

  localparam int MODE_BITS   = 2;
  localparam int GHOST_BITS  = 8;
  localparam int SIDE_BITS   = 15;
  localparam int BUDGET_BITS = 31;
  localparam int TUPLE_BITS  = 7;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CHUNK_MODE  = 3'd0,
    REG_GHOST_X     = 3'd1,
    REG_GHOST_Y     = 3'd2,
    REG_GHOST_Z     = 3'd3,
    REG_VOLUME_SIDE = 3'd4,
    REG_PLANE_SIDE  = 3'd5,
    REG_MEM_BUDGET  = 3'd6,
    REG_TUPLE_BYTES = 3'd7
  } cfg_reg_t;

  localparam logic [MODE_BITS-1:0] MODE_FULL = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_XY   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_YZ   = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_XZ   = 2'd3;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [SIDE_BITS-1:0]   VOLUME_SIDE_RST = 15'd16;
  localparam logic [SIDE_BITS-1:0]   PLANE_SIDE_RST  = 15'd64;
  localparam logic [BUDGET_BITS-1:0] MEM_BUDGET_RST  = 31'd134217728;
  localparam logic [TUPLE_BITS-1:0]  TUPLE_BYTES_RST = 7'd1;

endpackage

>>> sv/vct_if.sv
// Command and chunk channel interfaces of the volume chunk tiler.
interface vct_cmd_if #(
  parameter int COORD_BITS = vct_pkg::COORD_BITS_DEF
);
  logic valid;
  logic ready;
  logic cmd;
  logic signed [COORD_BITS-1:0] x_lo;
  logic signed [COORD_BITS-1:0] x_hi;
  logic signed [COORD_BITS-1:0] y_lo;
  logic signed [COORD_BITS-1:0] y_hi;
  logic signed [COORD_BITS-1:0] z_lo;
  logic signed [COORD_BITS-1:0] z_hi;

  modport source (output valid, cmd, x_lo, x_hi, y_lo, y_hi, z_lo, z_hi, input ready);
  modport sink (input valid, cmd, x_lo, x_hi, y_lo, y_hi, z_lo, z_hi, output ready);
endinterface

interface vct_chunk_if #(
  parameter int COORD_BITS = vct_pkg::COORD_BITS_DEF
);
  logic valid;
  logic ready;
  logic signed [COORD_BITS:0] out_x_lo;
  logic signed [COORD_BITS:0] out_x_hi;
  logic signed [COORD_BITS:0] out_y_lo;
  logic signed [COORD_BITS:0] out_y_hi;
  logic signed [COORD_BITS:0] out_z_lo;
  logic signed [COORD_BITS:0] out_z_hi;
  logic signed [COORD_BITS:0] in_x_lo;
  logic signed [COORD_BITS:0] in_x_hi;
  logic signed [COORD_BITS:0] in_y_lo;
  logic signed [COORD_BITS:0] in_y_hi;
  logic signed [COORD_BITS:0] in_z_lo;
  logic signed [COORD_BITS:0] in_z_hi;

  modport source (output valid, out_x_lo, out_x_hi, out_y_lo, out_y_hi, out_z_lo, out_z_hi,
                  in_x_lo, in_x_hi, in_y_lo, in_y_hi, in_z_lo, in_z_hi, input ready);
  modport sink (input valid, out_x_lo, out_x_hi, out_y_lo, out_y_hi, out_z_lo, out_z_hi,
                in_x_lo, in_x_hi, in_y_lo, in_y_hi, in_z_lo, in_z_hi, output ready);
endinterface

>>> sv/volume_chunk_tiler.sv
// Volume chunk tiler: walks a 3D extent chunk by chunk under a memory budget.
//
// cmds carries begin (latch extent, size the chunk) and next (advance) commands;
// chunks returns one result per command: the chunk's output extent and its
// ghost-padded input extent. With no chunk current every lo is 0, every hi -1.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block does not enforce this. One command
// is worked at a time; cmds.ready is high only when idle. A next steps the
// innermost cursor; an axis that wraps goes back to zero and carries outward.
// A begin with a zero budget skips sizing; otherwise the chunk is sized on one
// shared add/subtract unit: a shift-add product over the three steps and the
// tuple size (one multiplier bit per cycle) and, while over budget, up to three
// shrink rounds in walk order, of up to two restoring divisions each.
// The result sits in an output register; a stalled receiver holds it while
// the next command is taken and worked, and that result waits for the slot.
// Reset (synchronous) restores the register defaults and leaves no walk active.
`include "assert_macros.svh"

module volume_chunk_tiler #(
  parameter int COORD_BITS = vct_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [vct_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [vct_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  vct_cmd_if.sink                             cmds,
  vct_chunk_if.source                         chunks
);

  localparam int SW  = COORD_BITS + 1;                      // size, step, cursor
  localparam int PW  = 3 * SW + vct_pkg::TUPLE_BITS;        // chunk bytes
  localparam int AW  = PW + 1;                              // shared unit width
  localparam int CW  = $clog2(AW);
  localparam int EW  = COORD_BITS + 4;                      // emit arithmetic
  localparam int MW  = (SW > vct_pkg::SIDE_BITS) ? SW : vct_pkg::SIDE_BITS;
  localparam int CLW = vct_pkg::SIDE_BITS + 2;

  localparam logic signed [EW-1:0] ONE_E = EW'(1);
  localparam logic signed [EW-1:0] TOP_E = EW'((64'sd1 <<< COORD_BITS) - 64'sd1);

  localparam logic [1:0] MPH_S01   = 2'd0;
  localparam logic [1:0] MPH_S2    = 2'd1;
  localparam logic [1:0] MPH_TUPLE = 2'd2;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CLAMP = 10'b0000000010,
    S_MSET  = 10'b0000000100,
    S_MUL   = 10'b0000001000,
    S_TEST  = 10'b0000010000,
    S_DIVR  = 10'b0000100000,
    S_RTEST = 10'b0001000000,
    S_DIVS  = 10'b0010000000,
    S_NEXT  = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state;

  // configuration
  logic [vct_pkg::MODE_BITS-1:0]   chunk_mode;
  logic [vct_pkg::GHOST_BITS-1:0]  ghost [3];
  logic [vct_pkg::SIDE_BITS-1:0]   max_volume_side;
  logic [vct_pkg::SIDE_BITS-1:0]   max_plane_side;
  logic [vct_pkg::BUDGET_BITS-1:0] mem_budget_bytes;
  logic [vct_pkg::TUPLE_BITS-1:0]  tuple_bytes;

  // walk state
  logic signed [COORD_BITS-1:0] ext_lo [3];
  logic signed [COORD_BITS-1:0] ext_hi [3];
  logic [SW-1:0] axis_size [3];
  logic [SW-1:0] step [3];
  logic [SW-1:0] cursor [3];
  logic [1:0]    walk [3];
  logic          active;

  // sequencer and shared unit
  logic [1:0]    k;
  logic [1:0]    mph;
  logic [1:0]    lvl;
  logic [CW-1:0] cnt;
  logic [AW-1:0] acc;
  logic [AW-1:0] mc;
  logic [AW-1:0] mp;

  // result register
  logic                 ov;
  logic signed [SW-1:0] res_lo [3];
  logic signed [SW-1:0] res_hi [3];
  logic signed [SW-1:0] res_ilo [3];
  logic signed [SW-1:0] res_ihi [3];

  logic cmd_fire;
  assign cmds.ready = (state == S_IDLE);
  assign cmd_fire   = cmds.valid && cmds.ready;

  // ---- begin decode
  logic signed [COORD_BITS-1:0] in_lo [3];
  logic signed [COORD_BITS-1:0] in_hi [3];
  logic signed [SW-1:0]         in_dif [3];
  logic [SW-1:0]                in_size [3];
  logic                         begin_ok;
  logic [1:0]                   mode_walk [3];
  logic                         mode_flat;
  logic [1:0]                   flat_ax;

  assign in_lo[0] = cmds.x_lo;
  assign in_hi[0] = cmds.x_hi;
  assign in_lo[1] = cmds.y_lo;
  assign in_hi[1] = cmds.y_hi;
  assign in_lo[2] = cmds.z_lo;
  assign in_hi[2] = cmds.z_hi;

  always_comb begin
    begin_ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      in_dif[a]  = SW'(in_hi[a]) - SW'(in_lo[a]);
      in_size[a] = $unsigned(in_dif[a]) + SW'(1);
      if (in_hi[a] < in_lo[a]) begin
        begin_ok = 1'b0;
      end
    end
  end

  always_comb begin
    mode_flat = 1'b1;
    case (chunk_mode)
      vct_pkg::MODE_XY: begin
        mode_walk[0] = vct_pkg::AXIS_Z;
        mode_walk[1] = vct_pkg::AXIS_Y;
        mode_walk[2] = vct_pkg::AXIS_X;
        flat_ax      = vct_pkg::AXIS_Z;
      end
      vct_pkg::MODE_YZ: begin
        mode_walk[0] = vct_pkg::AXIS_X;
        mode_walk[1] = vct_pkg::AXIS_Z;
        mode_walk[2] = vct_pkg::AXIS_Y;
        flat_ax      = vct_pkg::AXIS_X;
      end
      vct_pkg::MODE_XZ: begin
        mode_walk[0] = vct_pkg::AXIS_Y;
        mode_walk[1] = vct_pkg::AXIS_Z;
        mode_walk[2] = vct_pkg::AXIS_X;
        flat_ax      = vct_pkg::AXIS_Y;
      end
      default: begin
        mode_walk[0] = vct_pkg::AXIS_Z;
        mode_walk[1] = vct_pkg::AXIS_Y;
        mode_walk[2] = vct_pkg::AXIS_X;
        flat_ax      = vct_pkg::AXIS_X;
        mode_flat    = 1'b0;
      end
    endcase
  end

  // ---- side limit clamp
  logic [vct_pkg::SIDE_BITS-1:0] lim;
  logic signed [CLW-1:0]         clamp_s [3];
  logic                          clamp_over [3];
  logic [SW-1:0]                 clamp_v [3];

  always_comb begin
    lim = (chunk_mode != vct_pkg::MODE_FULL && ghost[walk[0]] == '0) ?
          max_plane_side : max_volume_side;
    for (int a = 0; a < 3; a++) begin
      clamp_over[a] = MW'(step[a]) > MW'(lim);
      clamp_s[a]    = signed'(CLW'(lim)) - signed'(CLW'({ghost[a], 1'b0}));
      clamp_v[a]    = (clamp_s[a] <= 0) ? SW'(1) : SW'(clamp_s[a]);
    end
  end

  // ---- axis under work: shrink round k, or cursor level lvl
  logic [1:0] widx;
  logic [1:0] sel_ax;

  always_comb begin
    widx = (state == S_NEXT) ? lvl : k;
    case (widx)
      2'd0:    sel_ax = walk[0];
      2'd1:    sel_ax = walk[1];
      default: sel_ax = walk[2];
    endcase
  end

  // ---- shared add/subtract unit
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic          alu_sub;
  logic [AW:0]   alu_sum;
  logic          alu_ge;
  logic [AW-1:0] div_q_next;
  logic [AW-1:0] div_r_next;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_MUL: begin
        alu_a = acc;
        alu_b = mc;
      end
      S_DIVR, S_DIVS: begin
        alu_a   = {acc[AW-2:0], mp[AW-1]};
        alu_b   = mc;
        alu_sub = 1'b1;
      end
      S_TEST: begin
        alu_a   = AW'(mem_budget_bytes);
        alu_b   = acc;
        alu_sub = 1'b1;
      end
      S_RTEST: begin
        alu_a   = AW'(step[sel_ax]);
        alu_b   = mp;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
    alu_ge     = alu_sum[AW];                 // a >= b on subtract
    div_q_next = {mp[AW-2:0], alu_ge};
    div_r_next = alu_ge ? alu_sum[AW-1:0] : alu_a;
  end

  // ---- cursor advance
  logic [SW:0] cur_sum;
  logic        wrap;

  assign cur_sum = {1'b0, cursor[sel_ax]} + {1'b0, step[sel_ax]};
  assign wrap    = cur_sum >= {1'b0, axis_size[sel_ax]};

  // ---- result extents
  logic signed [EW-1:0] e_lo [3];
  logic signed [EW-1:0] e_hi [3];
  logic signed [EW-1:0] e_ilo [3];
  logic signed [EW-1:0] e_ihi [3];
  logic signed [EW-1:0] e_g [3];
  logic signed [EW-1:0] e_xlo [3];
  logic signed [EW-1:0] e_xhi [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      e_xlo[a] = EW'(ext_lo[a]);
      e_xhi[a] = EW'(ext_hi[a]);
      e_g[a]   = signed'(EW'(ghost[a]));
      e_lo[a]  = e_xlo[a] + signed'(EW'(cursor[a]));
      e_hi[a]  = e_lo[a] + signed'(EW'(step[a])) - ONE_E;
      e_ilo[a] = e_lo[a] - e_g[a];
      e_ihi[a] = e_hi[a] + e_g[a];
      if (e_ilo[a] < e_xlo[a]) begin
        e_ilo[a] = e_xlo[a];
      end
      if (e_ihi[a] > e_xhi[a]) begin
        e_ihi[a] = e_xhi[a];
      end
      if (e_hi[a] > TOP_E) begin
        e_hi[a] = TOP_E;
      end
    end
  end

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      ov               <= 1'b0;
      active           <= 1'b0;
      chunk_mode       <= vct_pkg::MODE_FULL;
      max_volume_side  <= vct_pkg::VOLUME_SIDE_RST;
      max_plane_side   <= vct_pkg::PLANE_SIDE_RST;
      mem_budget_bytes <= vct_pkg::MEM_BUDGET_RST;
      tuple_bytes      <= vct_pkg::TUPLE_BYTES_RST;
      k                <= '0;
      mph              <= MPH_S01;
      lvl              <= '0;
      cnt              <= '0;
      for (int a = 0; a < 3; a++) begin
        ghost[a]     <= '0;
        ext_lo[a]    <= '0;
        ext_hi[a]    <= '1;
        axis_size[a] <= '0;
        step[a]      <= '0;
        cursor[a]    <= '0;
        walk[a]      <= 2'(a);
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          vct_pkg::REG_CHUNK_MODE:  chunk_mode <= cfg_data[vct_pkg::MODE_BITS-1:0];
          vct_pkg::REG_GHOST_X:     ghost[0] <= cfg_data[vct_pkg::GHOST_BITS-1:0];
          vct_pkg::REG_GHOST_Y:     ghost[1] <= cfg_data[vct_pkg::GHOST_BITS-1:0];
          vct_pkg::REG_GHOST_Z:     ghost[2] <= cfg_data[vct_pkg::GHOST_BITS-1:0];
          vct_pkg::REG_VOLUME_SIDE: max_volume_side <= cfg_data[vct_pkg::SIDE_BITS-1:0];
          vct_pkg::REG_PLANE_SIDE:  max_plane_side <= cfg_data[vct_pkg::SIDE_BITS-1:0];
          vct_pkg::REG_MEM_BUDGET:  mem_budget_bytes <= cfg_data[vct_pkg::BUDGET_BITS-1:0];
          vct_pkg::REG_TUPLE_BYTES: tuple_bytes <= cfg_data[vct_pkg::TUPLE_BITS-1:0];
          default: ;
        endcase
      end

      if (ov && chunks.ready) begin
        ov <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            if (cmds.cmd == vct_pkg::CMD_NEXT) begin
              lvl   <= 2'd2;
              state <= active ? S_NEXT : S_EMIT;
            end else if (!begin_ok) begin
              active <= 1'b0;
              state  <= S_EMIT;
            end else begin
              for (int a = 0; a < 3; a++) begin
                ext_lo[a]    <= in_lo[a];
                ext_hi[a]    <= in_hi[a];
                axis_size[a] <= in_size[a];
                cursor[a]    <= '0;
                walk[a]      <= mode_walk[a];
                step[a]      <= (mode_flat && flat_ax == 2'(a)) ? SW'(1) : in_size[a];
              end
              active <= 1'b1;
              state  <= S_CLAMP;
            end
          end
        end

        S_CLAMP: begin
          for (int a = 0; a < 3; a++) begin
            if (clamp_over[a]) begin
              step[a] <= clamp_v[a];
            end
          end
          k     <= '0;
          state <= (mem_budget_bytes == '0) ? S_EMIT : S_MSET;
        end

        S_MSET: begin
          acc   <= '0;
          mc    <= AW'(step[0]);
          mp    <= AW'(step[1]);
          mph   <= MPH_S01;
          state <= S_MUL;
        end

        // shift-add product; a phase ends when the multiplier runs out of bits
        S_MUL: begin
          if (mp == '0) begin
            case (mph)
              MPH_S01: begin
                mc  <= acc;
                acc <= '0;
                mp  <= AW'(step[2]);
                mph <= MPH_S2;
              end
              MPH_S2: begin
                mc  <= acc;
                acc <= '0;
                mp  <= AW'(tuple_bytes);
                mph <= MPH_TUPLE;
              end
              default: begin
                state <= S_TEST;
              end
            endcase
          end else begin
            if (mp[0]) begin
              acc <= alu_sum[AW-1:0];
            end
            mc <= mc << 1;
            mp <= mp >> 1;
          end
        end

        // acc holds chunk bytes; !alu_ge means over budget
        S_TEST: begin
          if (k == 2'd3 || alu_ge) begin
            state <= S_EMIT;
          end else if (step[sel_ax] > SW'(1)) begin
            mp    <= acc;
            acc   <= '0;
            mc    <= AW'(mem_budget_bytes);
            cnt   <= '0;
            state <= S_DIVR;
          end else begin
            k <= k + 2'd1;
          end
        end

        S_DIVR: begin
          acc <= div_r_next;
          mp  <= div_q_next;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(AW - 1)) begin
            state <= S_RTEST;
          end
        end

        // mp holds the size-to-budget ratio
        S_RTEST: begin
          if (!alu_ge) begin
            step[sel_ax] <= SW'(1);
            k            <= k + 2'd1;
            state        <= S_MSET;
          end else begin
            mc    <= mp;
            mp    <= AW'(step[sel_ax]);
            acc   <= '0;
            cnt   <= '0;
            state <= S_DIVS;
          end
        end

        S_DIVS: begin
          acc <= div_r_next;
          mp  <= div_q_next;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(AW - 1)) begin
            step[sel_ax] <= div_q_next[SW-1:0];
            k            <= k + 2'd1;
            state        <= S_MSET;
          end
        end

        // innermost axis first; outermost overflow ends the walk
        S_NEXT: begin
          if (lvl == 2'd0) begin
            cursor[sel_ax] <= cur_sum[SW-1:0];
            if (wrap) begin
              active <= 1'b0;
            end
            state <= S_EMIT;
          end else if (wrap) begin
            cursor[sel_ax] <= '0;
            lvl            <= lvl - 2'd1;
          end else begin
            cursor[sel_ax] <= cur_sum[SW-1:0];
            state          <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (!ov || chunks.ready) begin
            ov <= 1'b1;
            for (int a = 0; a < 3; a++) begin
              if (active) begin
                res_lo[a]  <= e_lo[a][SW-1:0];
                res_hi[a]  <= e_hi[a][SW-1:0];
                res_ilo[a] <= e_ilo[a][SW-1:0];
                res_ihi[a] <= e_ihi[a][SW-1:0];
              end else begin
                res_lo[a]  <= '0;
                res_hi[a]  <= '1;
                res_ilo[a] <= '0;
                res_ihi[a] <= '1;
              end
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign chunks.valid    = ov;
  assign chunks.out_x_lo = res_lo[0];
  assign chunks.out_x_hi = res_hi[0];
  assign chunks.out_y_lo = res_lo[1];
  assign chunks.out_y_hi = res_hi[1];
  assign chunks.out_z_lo = res_lo[2];
  assign chunks.out_z_hi = res_hi[2];
  assign chunks.in_x_lo  = res_ilo[0];
  assign chunks.in_x_hi  = res_ihi[0];
  assign chunks.in_y_lo  = res_ilo[1];
  assign chunks.in_y_hi  = res_ihi[1];
  assign chunks.in_z_lo  = res_ilo[2];
  assign chunks.in_z_hi  = res_ihi[2];

  `VCT_ASSERT_NXT(a_next_idle_emits, cmd_fire && cmds.cmd == vct_pkg::CMD_NEXT && !active, state == S_EMIT)
  `VCT_ASSERT_IMP(a_walk_in_range, state == S_IDLE && active, cursor[0] < axis_size[0] && cursor[1] < axis_size[1] && cursor[2] < axis_size[2] && step[0] != '0 && step[1] != '0 && step[2] != '0)
  `VCT_ASSERT_IMP(a_result_from_emit, $rose(chunks.valid), $past(state == S_EMIT))
  `VCT_ASSERT_IMP(a_divisor_nonzero, state == S_DIVR || state == S_DIVS, mc != '0)

endmodule

>>> test/tb_top.sv
// Self-checking bench for the volume chunk tiler: a directed table, then random chunk walks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vct_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int RW = CB + 1;
  localparam longint FIELD_TOP = (longint'(1) << CB) - 1;

  typedef logic [RW-1:0] field_t;
  // element 0..5: output extent x_lo .. z_hi, 6..11: ghost-padded input extent
  typedef logic [11:0][RW-1:0] tile_t;

  typedef struct packed {
    logic            cmd;
    logic [5:0][CB-1:0] c;  // x_lo, x_hi, y_lo, y_hi, z_lo, z_hi
  } tile_cmd_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]   mode;
    logic [GHOST_BITS-1:0]  gx;
    logic [GHOST_BITS-1:0]  gy;
    logic [GHOST_BITS-1:0]  gz;
    logic [SIDE_BITS-1:0]   vol;
    logic [SIDE_BITS-1:0]   plane;
    logic [BUDGET_BITS-1:0] budget;
    logic [TUPLE_BITS-1:0]  tuple;
  } regs_t;

  typedef struct packed {
    logic      regs_row;
    regs_t     regs;
    logic      typed;
    tile_cmd_t c;
    tile_t     want;
  } row_t;

  localparam tile_t NO_TILE = {6{field_t'(-1), field_t'(0)}};
  localparam tile_t CUBE4   = {6{field_t'(3), field_t'(0)}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_CHUNK_MODE;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  vct_cmd_if   cmds ();
  vct_chunk_if chunks ();

  volume_chunk_tiler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmds      (cmds),
    .chunks    (chunks)
  );

  string field_name [12] = '{"out_x_lo", "out_x_hi", "out_y_lo", "out_y_hi", "out_z_lo",
                             "out_z_hi", "in_x_lo", "in_x_hi", "in_y_lo", "in_y_hi",
                             "in_z_lo", "in_z_hi"};

  tile_t tiles_due [$];
  row_t  dir_rows [$];
  int    mismatches = 0;
  int    src_idle = 35;
  int    snk_idle = 83;
  int    hold_cycles = 0;

  // register copy, reset values
  logic [MODE_BITS-1:0]   mode_q = MODE_FULL;
  logic [GHOST_BITS-1:0]  ghost_q [3] = '{0, 0, 0};
  logic [SIDE_BITS-1:0]   vol_q = VOLUME_SIDE_RST;
  logic [SIDE_BITS-1:0]   plane_q = PLANE_SIDE_RST;
  logic [BUDGET_BITS-1:0] budget_q = MEM_BUDGET_RST;
  logic [TUPLE_BITS-1:0]  tuple_q = TUPLE_BYTES_RST;

  // walk state; cursor is relative to the extent minimum
  longint     w_lo [3] = '{0, 0, 0};
  longint     w_hi [3] = '{-1, -1, -1};
  longint     w_len [3] = '{0, 0, 0};
  longint     w_step [3] = '{0, 0, 0};
  longint     w_pos [3] = '{0, 0, 0};
  logic [1:0] w_order [3] = '{AXIS_X, AXIS_Y, AXIS_Z};
  bit         w_on = 1'b0;

  initial forever #5 clk = ~clk;

  task automatic report(string what);
    mismatches++;
    // keep the log short if the block is badly off
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic longint unsigned chunk_bytes();
    longint unsigned p;
    p = w_step[0];
    p = p * w_step[1] * w_step[2] * tuple_q;
    return p;
  endfunction

  function automatic void start_walk(tile_cmd_t t);
    longint lo [3];
    longint hi [3];
    longint lim, s, g;
    longint unsigned bytes, ratio;
    logic [1:0] ax;
    for (int a = 0; a < 3; a++) begin
      lo[a] = $signed(t.c[2*a]);
      hi[a] = $signed(t.c[2*a+1]);
    end
    if (hi[0] < lo[0] || hi[1] < lo[1] || hi[2] < lo[2]) begin
      w_on = 1'b0;
      return;
    end
    for (int a = 0; a < 3; a++) begin
      w_lo[a] = lo[a];
      w_hi[a] = hi[a];
      w_len[a] = hi[a] - lo[a] + 1;
      w_step[a] = w_len[a];
      w_pos[a] = 0;
    end
    case (mode_q)
      MODE_XY: begin
        w_order = '{AXIS_Z, AXIS_Y, AXIS_X};
        w_step[AXIS_Z] = 1;
      end
      MODE_YZ: begin
        w_order = '{AXIS_X, AXIS_Z, AXIS_Y};
        w_step[AXIS_X] = 1;
      end
      MODE_XZ: begin
        w_order = '{AXIS_Y, AXIS_Z, AXIS_X};
        w_step[AXIS_Y] = 1;
      end
      default: w_order = '{AXIS_Z, AXIS_Y, AXIS_X};
    endcase
    // planar limit only when the slab axis carries no ghost cells
    lim = vol_q;
    if (mode_q != MODE_FULL && ghost_q[w_order[0]] == 0) lim = plane_q;
    for (int a = 0; a < 3; a++) begin
      if (w_step[a] > lim) begin
        g = ghost_q[a];
        s = lim - 2 * g;
        w_step[a] = (s < 1) ? 1 : s;
      end
    end
    if (budget_q != 0) begin
      bytes = chunk_bytes();
      for (int a = 0; a < 3 && bytes > budget_q; a++) begin
        ax = w_order[a];
        ratio = bytes / budget_q;
        if (w_step[ax] > 1) begin
          if (ratio > w_step[ax]) w_step[ax] = 1;
          else w_step[ax] = w_step[ax] / ratio;
        end
        bytes = chunk_bytes();
      end
    end
    w_on = 1'b1;
  endfunction

  function automatic void step_walk();
    logic [1:0] o0, o1, o2;
    if (!w_on) return;
    o0 = w_order[0];
    o1 = w_order[1];
    o2 = w_order[2];
    w_pos[o2] += w_step[o2];
    if (w_pos[o2] >= w_len[o2]) begin
      w_pos[o2] = 0;
      w_pos[o1] += w_step[o1];
      if (w_pos[o1] >= w_len[o1]) begin
        w_pos[o1] = 0;
        w_pos[o0] += w_step[o0];
      end
    end
    if (w_pos[o0] >= w_len[o0]) w_on = 1'b0;
  endfunction

  function automatic tile_t chunk_after(tile_cmd_t t);
    tile_t r;
    longint lo, hi, ilo, ihi, g;
    if (t.cmd == CMD_BEGIN) start_walk(t);
    else step_walk();
    if (!w_on) return NO_TILE;
    for (int a = 0; a < 3; a++) begin
      g = ghost_q[a];
      lo = w_lo[a] + w_pos[a];
      hi = lo + w_step[a] - 1;
      ilo = lo - g;
      ihi = hi + g;
      if (ilo < w_lo[a]) ilo = w_lo[a];
      if (ihi > w_hi[a]) ihi = w_hi[a];
      if (hi > FIELD_TOP) hi = FIELD_TOP;
      r[2*a]   = field_t'(lo);
      r[2*a+1] = field_t'(hi);
      r[6+2*a] = field_t'(ilo);
      r[7+2*a] = field_t'(ihi);
    end
    return r;
  endfunction

  function automatic tile_cmd_t cmd_of(logic op, int xl, int xh, int yl, int yh, int zl,
                                      int zh);
    tile_cmd_t t;
    t.cmd = op;
    t.c = {CB'(zh), CB'(zl), CB'(yh), CB'(yl), CB'(xh), CB'(xl)};
    return t;
  endfunction

  function automatic tile_cmd_t rand_cmd(logic op);
    tile_cmd_t t;
    t.cmd = op;
    t.c = {$urandom, $urandom, $urandom};
    return t;
  endfunction

  // well-formed begin: mostly small extents anywhere in the coordinate range
  function automatic tile_cmd_t rand_begin();
    tile_cmd_t t;
    int span, base;
    t.cmd = CMD_BEGIN;
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(9))
        0:       span = $urandom_range(65536, 1);
        1, 2:    span = $urandom_range(400, 1);
        default: span = $urandom_range(40, 1);
      endcase
      base = $urandom_range(65536 - span) - 32768;
      t.c[2*a]   = CB'(base);
      t.c[2*a+1] = CB'(base + span - 1);
    end
    return t;
  endfunction

  function automatic logic [GHOST_BITS-1:0] rand_ghost();
    return ($urandom_range(2) == 0) ? $urandom_range(255) : $urandom_range(3);
  endfunction

  function automatic regs_t rand_regs();
    regs_t k;
    k.mode = $urandom_range(3);
    k.gx = rand_ghost();
    k.gy = rand_ghost();
    k.gz = rand_ghost();
    k.vol = ($urandom_range(3) == 0) ? $urandom_range(16384, 16) : $urandom_range(64, 16);
    k.plane = ($urandom_range(3) == 0) ? $urandom_range(16384, 64) : $urandom_range(256, 64);
    case ($urandom_range(3))
      0:       k.budget = '0;
      1:       k.budget = $urandom_range(50000, 1);
      2:       k.budget = $urandom_range(5000000, 50000);
      default: k.budget = $urandom;
    endcase
    if ($urandom_range(9) == 0) k.tuple = $urandom_range(1) ? '1 : '0;
    else k.tuple = $urandom_range(64, 1);
    return k;
  endfunction

  function automatic void add_cmd(tile_cmd_t t, bit typed = 1'b0, tile_t want = '0);
    row_t r;
    r = '0;
    r.c = t;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_regs(regs_t k);
    row_t r;
    r = '0;
    r.regs_row = 1'b1;
    r.regs = k;
    dir_rows.push_back(r);
  endfunction

  // called at a falling edge; leaves the write enable high for a following write
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      REG_CHUNK_MODE:  mode_q = val[MODE_BITS-1:0];
      REG_GHOST_X:     ghost_q[AXIS_X] = val[GHOST_BITS-1:0];
      REG_GHOST_Y:     ghost_q[AXIS_Y] = val[GHOST_BITS-1:0];
      REG_GHOST_Z:     ghost_q[AXIS_Z] = val[GHOST_BITS-1:0];
      REG_VOLUME_SIDE: vol_q = val[SIDE_BITS-1:0];
      REG_PLANE_SIDE:  plane_q = val[SIDE_BITS-1:0];
      REG_MEM_BUDGET:  budget_q = val[BUDGET_BITS-1:0];
      REG_TUPLE_BYTES: tuple_q = val[TUPLE_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_regs(regs_t k);
    write_reg(REG_CHUNK_MODE, k.mode);
    write_reg(REG_GHOST_X, k.gx);
    write_reg(REG_GHOST_Y, k.gy);
    write_reg(REG_GHOST_Z, k.gz);
    write_reg(REG_VOLUME_SIDE, k.vol);
    write_reg(REG_PLANE_SIDE, k.plane);
    write_reg(REG_MEM_BUDGET, k.budget);
    write_reg(REG_TUPLE_BYTES, k.tuple);
    cfg_we = 1'b0;
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_cmd(tile_cmd_t t, bit typed = 1'b0, tile_t want = '0);
    tile_t predicted;
    while ($urandom_range(99) < src_idle) begin
      cmds.valid = 1'b0;
      @(negedge clk);
    end
    cmds.valid = 1'b1;
    cmds.cmd = t.cmd;
    cmds.x_lo = t.c[0];
    cmds.x_hi = t.c[1];
    cmds.y_lo = t.c[2];
    cmds.y_hi = t.c[3];
    cmds.z_lo = t.c[4];
    cmds.z_hi = t.c[5];
    @(posedge clk);
    while (!cmds.ready) @(posedge clk);
    predicted = chunk_after(t);
    tiles_due.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic drain_tiles();
    cmds.valid = 1'b0;
    while (tiles_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    chunks.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        chunks.ready = 1'b0;
        hold_cycles--;
      end else begin
        chunks.ready = ($urandom_range(99) >= snk_idle);
      end
    end
  end

  always @(posedge clk) begin
    tile_t seen, due;
    if (!rst && chunks.valid && chunks.ready) begin
      seen = {chunks.in_z_hi, chunks.in_z_lo, chunks.in_y_hi, chunks.in_y_lo,
              chunks.in_x_hi, chunks.in_x_lo, chunks.out_z_hi, chunks.out_z_lo,
              chunks.out_y_hi, chunks.out_y_lo, chunks.out_x_hi, chunks.out_x_lo};
      if (tiles_due.size() == 0) begin
        report("chunk transfer with nothing due");
      end else begin
        due = tiles_due.pop_front();
        for (int i = 0; i < 12; i++)
          if (seen[i] !== due[i])
            report($sformatf("%s got %0d want %0d", field_name[i], $signed(seen[i]),
                             $signed(due[i])));
      end
    end
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    row_t  r;
    regs_t k;
    int    sent, hops;
    bit    paused;
    cmds.valid = 1'b0;
    cmds.cmd = CMD_BEGIN;
    cmds.x_lo = '0;
    cmds.x_hi = '0;
    cmds.y_lo = '0;
    cmds.y_hi = '0;
    cmds.z_lo = '0;
    cmds.z_hi = '0;

    // reset registers
    add_cmd(cmd_of(CMD_NEXT, 0, 0, 0, 0, 0, 0), 1'b1, NO_TILE);   // no walk yet
    add_cmd(cmd_of(CMD_BEGIN, 0, 3, 0, 3, 0, 3), 1'b1, CUBE4);
    add_cmd(cmd_of(CMD_NEXT, -1, -1, -1, -1, -1, -1), 1'b1, NO_TILE);  // walk over
    add_cmd(cmd_of(CMD_BEGIN, 5, 4, 0, 0, 0, 0), 1'b1, NO_TILE);  // hi below lo
    add_cmd(cmd_of(CMD_BEGIN, 0, 0, 0, 0, 3, 2), 1'b1, NO_TILE);
    add_cmd(cmd_of(CMD_BEGIN, -32768, 32767, -32768, 32767, -32768, 32767));
    add_cmd(cmd_of(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    add_cmd(cmd_of(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    add_cmd(cmd_of(CMD_BEGIN, 0, 20, 0, 0, 0, 0));
    add_cmd(cmd_of(CMD_NEXT, 0, 0, 0, 0, 0, 0));    // ragged chunk past the extent
    add_cmd(cmd_of(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    // planes, ghost on the slab axis keeps the volume limit
    add_regs(regs_t'{MODE_XY, 8'd2, 8'd3, 8'd255, 15'd16, 15'd64, 31'd0, 7'd64});
    add_cmd(cmd_of(CMD_BEGIN, -10, 40, -10, 40, -10, 40));
    add_cmd(cmd_of(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    add_cmd(cmd_of(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    // wide ghosts push the clamped step down to its floor
    add_regs(regs_t'{MODE_YZ, 8'd255, 8'd255, 8'd255, 15'd16, 15'd64, 31'h7FFFFFFF, 7'd127});
    add_cmd(cmd_of(CMD_BEGIN, -32768, -32768, 0, 100, 0, 100));
    add_cmd(cmd_of(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    // one-byte budget shrinks every axis to 1
    add_regs(regs_t'{MODE_XZ, 8'd0, 8'd0, 8'd0, 15'd16384, 15'd16384, 31'd1, 7'd1});
    add_cmd(cmd_of(CMD_BEGIN, 0, 99, 0, 99, 0, 99));
    add_cmd(cmd_of(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    // zero tuple size: nothing is shrunk
    add_regs(regs_t'{MODE_FULL, 8'd1, 8'd1, 8'd1, 15'h7FFF, 15'd64, 31'd1000, 7'd0});
    add_cmd(cmd_of(CMD_BEGIN, 0, 199, 0, 9, 0, 9));
    add_cmd(cmd_of(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    add_regs(regs_t'{MODE_FULL, 8'd0, 8'd0, 8'd0, 15'd16, 15'd64, 31'd1000, 7'd3});
    add_cmd(cmd_of(CMD_BEGIN, 0, 15, 0, 15, 0, 15));
    add_cmd(cmd_of(CMD_NEXT, 0, 0, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.regs_row) begin
        drain_tiles();
        load_regs(r.regs);
      end else begin
        send_cmd(r.c, r.typed, r.want);
      end
    end
    drain_tiles();

    for (int p = 0; p < 6; p++) begin
      @(posedge clk);
      src_idle = (p < 2) ? 35 : (p < 4) ? 83 : 0;
      snk_idle = (p < 2) ? 83 : (p < 4) ? 35 : 0;
      // long receiver hold-off while the sender keeps offering back to back
      if (p == 4) hold_cycles = 400;
      @(negedge clk);
      if (p == 0) k = regs_t'{MODE_FULL, 8'd0, 8'd0, 8'd0, 15'd16, 15'd64, 31'd0, 7'd1};
      else if (p == 1)
        k = regs_t'{MODE_XZ, 8'd255, 8'd255, 8'd255, 15'd16384, 15'd16384, 31'h7FFFFFFF,
                    7'd64};
      else k = rand_regs();
      load_regs(k);
      sent = 0;
      paused = 1'b0;
      while (sent < 150) begin
        if (p == 3 && sent >= 75 && !paused) begin
          drain_tiles();
          paused = 1'b1;
        end
        case ($urandom_range(19))
          0, 1: begin
            send_cmd(rand_cmd(CMD_BEGIN));   // mostly rejected
            sent++;
          end
          2: begin
            send_cmd(rand_cmd(CMD_NEXT));
            sent++;
          end
          default: begin
            send_cmd(rand_begin());
            sent++;
            hops = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(8);
            repeat (hops) begin
              send_cmd(rand_cmd(CMD_NEXT));
              sent++;
            end
          end
        endcase
      end
      if (p < 5) drain_tiles();
    end

    cmds.valid = 1'b0;
    hops = 0;
    while (tiles_due.size() != 0 && hops < 20000) begin
      @(posedge clk);
      hops++;
    end
    repeat (20) @(posedge clk);
    if (tiles_due.size() != 0)
      report($sformatf("%0d chunk results never arrived", tiles_due.size()));
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
